@@ sv/cef_pkg.sv @@
// Package for the coalescing event FIFO: field widths, codes, event record and controller states.
`timescale 1ns / 1ps

package cef_pkg;

  localparam int CEF_DEPTH    = 64;
  localparam int DELTA_W      = 16;
  localparam int BUTTONS_W    = 8;
  localparam int UNITS_W      = 2;
  localparam int TIME_W       = 32;
  localparam int READ_COUNT_W = 6;
  localparam int STATUS_W     = 2;

  // Command codes carried on in_func.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // One stored event, as held in a single memory word.
  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [UNITS_W-1:0]        units;
    logic [BUTTONS_W-1:0]      buttons;
    logic [TIME_W-1:0]         evt_time;
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR_CHECK,
    ST_RD_RUN
  } state_t;

  // Two nonzero deltas of opposite sign block a merge.
  function automatic logic opposite(input logic signed [DELTA_W-1:0] a,
                                    input logic signed [DELTA_W-1:0] b);
    return (a != '0) && (b != '0) && (a[DELTA_W-1] != b[DELTA_W-1]);
  endfunction

  function automatic logic signed [DELTA_W-1:0] sat_add(
      input logic signed [DELTA_W-1:0] a,
      input logic signed [DELTA_W-1:0] b);
    logic signed [DELTA_W:0] sum;
    sum = {a[DELTA_W-1], a} + {b[DELTA_W-1], b};
    if (sum[DELTA_W] != sum[DELTA_W-1]) begin
      return sum[DELTA_W] ? {1'b1, {(DELTA_W-1){1'b0}}} : {1'b0, {(DELTA_W-1){1'b1}}};
    end
    return sum[DELTA_W-1:0];
  endfunction

endpackage

@@ sv/coalescing_event_fifo.sv @@
// Coalescing pointer-event FIFO built around one synchronous event memory.
`timescale 1ns / 1ps

// Channel  | Handshake            | Word
// ---------+----------------------+------------------------------------------------
// in_      | start & !busy        | func, deltas, buttons, units, time, read count
// out_     | out_valid, one cycle | status, merged, has_event, event fields, last
//
// A write reads the newest entry from the event memory, then merges the new event
// into it and writes it back, or appends the new event, in the write-check state.
// A read returns one event per memory read in the read state until the count or
// the FIFO runs out; a read finding nothing answers from idle. Results are registered.
// Reset clears both pointers, so the FIFO starts empty; the memory is not cleared.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module coalescing_event_fifo
  import cef_pkg::*;
#(
  parameter int DEPTH = CEF_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic signed [DELTA_W-1:0]   in_delta_x,
  input  logic signed [DELTA_W-1:0]   in_delta_y,
  input  logic [BUTTONS_W-1:0]        in_buttons,
  input  logic [UNITS_W-1:0]          in_delta_units,
  input  logic [TIME_W-1:0]           in_event_time,
  input  logic [READ_COUNT_W-1:0]     in_read_count,
  output logic                        out_valid,
  output logic [STATUS_W-1:0]         out_status,
  output logic                        out_merged,
  output logic                        out_has_event,
  output logic signed [DELTA_W-1:0]   out_delta_x,
  output logic signed [DELTA_W-1:0]   out_delta_y,
  output logic [BUTTONS_W-1:0]        out_buttons,
  output logic [UNITS_W-1:0]          out_units,
  output logic [TIME_W-1:0]           out_time,
  output logic                        out_last
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

  state_t state_r, state_nxt;

  logic [PTR_W-1:0]        wp_r, wp_nxt;
  logic [PTR_W-1:0]        rp_r, rp_nxt;
  logic [READ_COUNT_W-1:0] rem_r, rem_nxt;

  event_t                  mem [DEPTH];
  event_t                  rd_data_r;
  event_t                  new_evt_r;
  logic                    mem_we;
  logic [PTR_W-1:0]        mem_waddr;
  logic [PTR_W-1:0]        mem_raddr;
  event_t                  mem_wdata;

  logic                    res_valid;
  logic [STATUS_W-1:0]     res_status;
  logic                    res_merged;
  logic                    res_has;
  logic                    res_last;

  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic                    out_merged_r;
  logic                    out_has_event_r;
  logic                    out_last_r;

  logic                    accept;
  logic                    empty;
  logic [PTR_W-1:0]        newest;
  logic [PTR_W-1:0]        wp_adv;
  logic [PTR_W-1:0]        rp_adv;
  logic                    can_merge;
  logic                    rd_final;
  event_t                  merged_evt;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign empty  = (wp_r == rp_r);
  assign newest = (wp_r == '0) ? PTR_MAX : wp_r - 1'b1;
  assign wp_adv = (wp_r == PTR_MAX) ? '0 : wp_r + 1'b1;
  assign rp_adv = (rp_r == PTR_MAX) ? '0 : rp_r + 1'b1;

  // rd_data_r holds the newest entry during the write check.
  assign can_merge = !empty
                     && !opposite(new_evt_r.dx, rd_data_r.dx)
                     && !opposite(new_evt_r.dy, rd_data_r.dy)
                     && (new_evt_r.buttons == rd_data_r.buttons)
                     && (new_evt_r.units == rd_data_r.units);

  always_comb begin
    merged_evt          = rd_data_r;
    merged_evt.dx       = sat_add(rd_data_r.dx, new_evt_r.dx);
    merged_evt.dy       = sat_add(rd_data_r.dy, new_evt_r.dy);
    merged_evt.evt_time = new_evt_r.evt_time;
  end

  // The final word of a read is either the last one asked for or the last one held.
  assign rd_final = (rem_r == READ_COUNT_W'(1)) || (rp_adv == wp_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_WRITE) begin
            state_nxt = ST_WR_CHECK;
          end else if ((in_read_count != '0) && !empty) begin
            state_nxt = ST_RD_RUN;
          end
        end
      end
      ST_WR_CHECK: begin
        state_nxt = ST_IDLE;
      end
      ST_RD_RUN: begin
        if (rd_final) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = wp_r;
    mem_wdata  = new_evt_r;
    mem_raddr  = rp_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    rem_nxt    = rem_r;
    res_valid  = 1'b0;
    res_status = STAT_OK;
    res_merged = 1'b0;
    res_has    = 1'b0;
    res_last   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_WRITE) begin
            mem_raddr = newest;
          end else if ((in_read_count == '0) || empty) begin
            res_valid  = 1'b1;
            res_status = STAT_EMPTY;
          end else begin
            rem_nxt = in_read_count;
          end
        end
      end
      ST_WR_CHECK: begin
        res_valid = 1'b1;
        if (can_merge) begin
          mem_we     = 1'b1;
          mem_waddr  = newest;
          mem_wdata  = merged_evt;
          res_merged = 1'b1;
        end else if (wp_adv == rp_r) begin
          res_status = STAT_FULL;
        end else begin
          mem_we = 1'b1;
          wp_nxt = wp_adv;
        end
      end
      ST_RD_RUN: begin
        rp_nxt    = rp_adv;
        rem_nxt   = rem_r - 1'b1;
        res_valid = 1'b1;
        res_has   = 1'b1;
        res_last  = rd_final;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && (in_func == FUNC_WRITE)) begin
      new_evt_r.dx       <= in_delta_x;
      new_evt_r.dy       <= in_delta_y;
      new_evt_r.buttons  <= in_buttons;
      new_evt_r.units    <= in_delta_units;
      new_evt_r.evt_time <= in_event_time;
    end
    out_status_r    <= res_status;
    out_merged_r    <= res_merged;
    out_has_event_r <= res_has;
    out_last_r      <= res_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= res_valid;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_merged    = out_merged_r;
  assign out_has_event = out_has_event_r;
  assign out_last      = out_last_r;
  assign out_delta_x   = out_has_event_r ? rd_data_r.dx       : '0;
  assign out_delta_y   = out_has_event_r ? rd_data_r.dy       : '0;
  assign out_buttons   = out_has_event_r ? rd_data_r.buttons  : '0;
  assign out_units     = out_has_event_r ? rd_data_r.units    : '0;
  assign out_time      = out_has_event_r ? rd_data_r.evt_time : '0;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the coalescing pointer-event FIFO.
`timescale 1ns / 1ps

module testbench;
  import cef_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_CYCLES = 12;
  localparam int ITEM_TARGET = 430;
  localparam int QUIET_TAIL  = 60;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 300000;

  // One command word as presented on the input channel, plus pacing controls.
  typedef struct {
    logic                      func;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [BUTTONS_W-1:0]      buttons;
    logic [UNITS_W-1:0]        units;
    logic [TIME_W-1:0]         evt_time;
    logic [READ_COUNT_W-1:0]   count;
    int                        gap_after;
    bit                        drain_first;
  } command_t;

  // One result word as it should appear on the output channel.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                merged;
    logic                has_event;
    event_t              ev;
    logic                last;
  } fifo_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_func = FUNC_WRITE;
  logic signed [DELTA_W-1:0] in_delta_x = '0;
  logic signed [DELTA_W-1:0] in_delta_y = '0;
  logic [BUTTONS_W-1:0] in_buttons = '0;
  logic [UNITS_W-1:0] in_delta_units = '0;
  logic [TIME_W-1:0] in_event_time = '0;
  logic [READ_COUNT_W-1:0] in_read_count = '0;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic out_merged;
  logic out_has_event;
  logic signed [DELTA_W-1:0] out_delta_x;
  logic signed [DELTA_W-1:0] out_delta_y;
  logic [BUTTONS_W-1:0] out_buttons;
  logic [UNITS_W-1:0] out_units;
  logic [TIME_W-1:0] out_time;
  logic out_last;

  command_t   cmd_queue[$];
  fifo_word_t awaited_words[$];

  // Shadow copy of the event ring and its pointers.
  event_t ring [CEF_DEPTH];
  int head_idx = 0;
  int tail_idx = 0;

  int issued_total = 0;
  int accepted_total = 0;
  int error_count = 0;
  int cycle_count = 0;
  int n_writes = 0;
  int n_merged = 0;
  int n_full = 0;
  int n_reads = 0;
  int n_returned = 0;
  int n_empty = 0;
  int idle_pct = 0;
  int gap_left = 0;
  bit hold_next = 1'b0;

  coalescing_event_fifo #(.DEPTH(CEF_DEPTH)) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_delta_x    (in_delta_x),
    .in_delta_y    (in_delta_y),
    .in_buttons    (in_buttons),
    .in_delta_units(in_delta_units),
    .in_event_time (in_event_time),
    .in_read_count (in_read_count),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_merged    (out_merged),
    .out_has_event (out_has_event),
    .out_delta_x   (out_delta_x),
    .out_delta_y   (out_delta_y),
    .out_buttons   (out_buttons),
    .out_units     (out_units),
    .out_time      (out_time),
    .out_last      (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int next_slot(input int idx);
    return (idx + 1 >= CEF_DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic bit signs_clash(input logic signed [DELTA_W-1:0] a,
                                     input logic signed [DELTA_W-1:0] b);
    int ia;
    int ib;
    ia = a;
    ib = b;
    return (ia != 0) && (ib != 0) && ((ia < 0) != (ib < 0));
  endfunction

  function automatic logic signed [DELTA_W-1:0] clamp_sum(
      input logic signed [DELTA_W-1:0] a,
      input logic signed [DELTA_W-1:0] b);
    int s;
    s = int'(a) + int'(b);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return DELTA_W'(s);
  endfunction

  // Works out the result words of one accepted command and updates the shadow ring.
  task automatic apply_command(input command_t c);
    fifo_word_t w;
    int newest;
    int taken;
    w = '0;
    if (c.func == FUNC_WRITE) begin
      n_writes++;
      newest = (tail_idx == 0) ? CEF_DEPTH - 1 : tail_idx - 1;
      w.status = STAT_OK;
      w.last = 1'b1;
      if (tail_idx != head_idx && !signs_clash(c.dx, ring[newest].dx) &&
          !signs_clash(c.dy, ring[newest].dy) && ring[newest].buttons == c.buttons &&
          ring[newest].units == c.units) begin
        ring[newest].dx = clamp_sum(ring[newest].dx, c.dx);
        ring[newest].dy = clamp_sum(ring[newest].dy, c.dy);
        ring[newest].evt_time = c.evt_time;
        w.merged = 1'b1;
        n_merged++;
      end else if (next_slot(tail_idx) == head_idx) begin
        w.status = STAT_FULL;
        n_full++;
      end else begin
        ring[tail_idx].dx = c.dx;
        ring[tail_idx].dy = c.dy;
        ring[tail_idx].buttons = c.buttons;
        ring[tail_idx].units = c.units;
        ring[tail_idx].evt_time = c.evt_time;
        tail_idx = next_slot(tail_idx);
      end
      awaited_words.push_back(w);
    end else begin
      n_reads++;
      taken = 0;
      while (taken < int'(c.count) && head_idx != tail_idx) begin
        w = '0;
        w.status = STAT_OK;
        w.has_event = 1'b1;
        w.ev = ring[head_idx];
        w.last = (taken + 1 == int'(c.count)) || (next_slot(head_idx) == tail_idx);
        awaited_words.push_back(w);
        head_idx = next_slot(head_idx);
        taken++;
      end
      n_returned += taken;
      if (taken == 0) begin
        w = '0;
        w.status = STAT_EMPTY;
        w.last = 1'b1;
        awaited_words.push_back(w);
        n_empty++;
      end
    end
  endtask

  task automatic queue_command(input command_t c);
    c.gap_after = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 7) : 0;
    c.drain_first = hold_next;
    hold_next = 1'b0;
    cmd_queue.push_back(c);
    issued_total++;
  endtask

  task automatic push_write(input int dx, input int dy, input int buttons, input int units,
                            input logic [TIME_W-1:0] evt_time);
    command_t c;
    c.func = FUNC_WRITE;
    c.dx = DELTA_W'(dx);
    c.dy = DELTA_W'(dy);
    c.buttons = BUTTONS_W'(buttons);
    c.units = UNITS_W'(units);
    c.evt_time = evt_time;
    c.count = READ_COUNT_W'($urandom);
    queue_command(c);
  endtask

  task automatic push_read(input int count);
    command_t c;
    c.func = FUNC_READ;
    c.dx = DELTA_W'($urandom);
    c.dy = DELTA_W'($urandom);
    c.buttons = BUTTONS_W'($urandom);
    c.units = UNITS_W'($urandom);
    c.evt_time = $urandom;
    c.count = READ_COUNT_W'(count);
    queue_command(c);
  endtask

  // Neighboring writes differ in one button bit, so none of them coalesce.
  task automatic fill_run(input int len);
    int base;
    base = $urandom_range(0, 255);
    for (int k = 0; k < len; k++) begin
      push_write($urandom_range(0, 65535), $urandom_range(0, 65535), base ^ (k & 1),
                 $urandom_range(0, 3), $urandom);
    end
  endtask

  // Delta for a coalescing run: zero, large enough to saturate, or small.
  function automatic int pick_delta(input bit neg);
    int m;
    case ($urandom_range(0, 3))
      0: m = 0;
      1: m = neg ? $urandom_range(16384, 32768) : $urandom_range(16384, 32767);
      default: m = $urandom_range(1, 200);
    endcase
    return neg ? -m : m;
  endfunction

  always @(posedge clk) begin : drive_proc
    int idle;
    command_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      idle = 0;
      if (start && !busy) begin
        apply_command(nxt);
        accepted_total++;
        idle = nxt.gap_after;
      end else if (!start) begin
        idle = gap_left;
      end
      if (start && busy) begin
        // The block has not taken the word yet; keep it on the ports.
      end else if (idle > 0) begin
        start <= 1'b0;
        gap_left = idle - 1;
      end else if (cmd_queue.size() != 0 &&
                   !(cmd_queue[0].drain_first && awaited_words.size() != 0)) begin
        nxt = cmd_queue.pop_front();
        gap_left = 0;
        start <= 1'b1;
        in_func <= nxt.func;
        in_delta_x <= nxt.dx;
        in_delta_y <= nxt.dy;
        in_buttons <= nxt.buttons;
        in_delta_units <= nxt.units;
        in_event_time <= nxt.evt_time;
        in_read_count <= nxt.count;
      end else begin
        start <= 1'b0;
        gap_left = 0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_proc
    fifo_word_t want;
    if (rst_n && out_valid) begin
      if (awaited_words.size() == 0) begin
        $error("result word arrived with nothing expected");
        error_count++;
      end else begin
        want = awaited_words.pop_front();
        check_field("out_status", 32'(want.status), 32'(out_status));
        check_field("out_merged", 32'(want.merged), 32'(out_merged));
        check_field("out_has_event", 32'(want.has_event), 32'(out_has_event));
        check_field("out_delta_x", 32'(unsigned'(want.ev.dx)), 32'(unsigned'(out_delta_x)));
        check_field("out_delta_y", 32'(unsigned'(want.ev.dy)), 32'(unsigned'(out_delta_y)));
        check_field("out_buttons", 32'(want.ev.buttons), 32'(out_buttons));
        check_field("out_units", 32'(want.ev.units), 32'(out_units));
        check_field("out_time", want.ev.evt_time, out_time);
        check_field("out_last", 32'(want.last), 32'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int kind;
    int len;
    int b;
    int u;
    bit sx;
    bit sy;

    // Directed part: empty reads, saturating merges, every merge blocker, partial reads.
    idle_pct = 30;
    push_read(5);
    push_read(0);
    push_write(32767, -32768, 8'hFF, 3, 32'hFFFF_FFFF);
    push_write(1, -1, 8'hFF, 3, 32'h0);
    push_write(0, 0, 8'hFF, 3, 32'd12345);
    push_write(-1, 0, 8'hFF, 3, 32'd7);
    push_write(-100, 5, 8'hFF, 3, 32'd8);
    push_write(0, -3, 8'hFF, 3, 32'd9);
    push_write(0, -3, 8'hFE, 3, 32'd10);
    push_write(0, -3, 8'hFE, 2, 32'd11);
    push_read(0);
    push_read(2);
    push_read(63);
    push_read(1);
    push_write(-32768, 32767, 8'h00, 0, 32'h0);
    push_write(-32768, 32767, 8'h00, 0, 32'h1);
    push_write(-1, 1, 8'h00, 0, 32'h8000_0000);
    push_read(63);

    // Random part: starts by running the ring into its full state.
    hold_next = 1'b1;
    fill_run(66);
    while (issued_total < ITEM_TARGET) begin
      if (issued_total > ITEM_TARGET - QUIET_TAIL) idle_pct = 0;
      else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 20;
          default: idle_pct = 50;
        endcase
        if ($urandom_range(0, 7) == 0) hold_next = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // Coalescing run; now and then one axis flips sign to break it.
        b = $urandom_range(0, 255);
        u = $urandom_range(0, 3);
        sx = $urandom_range(0, 1);
        sy = $urandom_range(0, 1);
        len = $urandom_range(2, 8);
        for (int k = 0; k < len; k++) begin
          push_write(pick_delta(sx ^ ($urandom_range(0, 9) == 0)),
                     pick_delta(sy ^ ($urandom_range(0, 9) == 0)), b, u, $urandom);
        end
        if ($urandom_range(0, 1) == 0) push_read($urandom_range(1, 63));
      end else if (kind == 4) begin
        len = $urandom_range(20, 70);
        if (len > ITEM_TARGET - issued_total) len = ITEM_TARGET - issued_total;
        fill_run(len);
      end else if (kind <= 6) begin
        push_read(($urandom_range(0, 3) == 0) ? 63 : $urandom_range(0, 63));
      end else if (kind <= 8) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          push_write($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 255), $urandom_range(0, 3), $urandom);
        end
      end else begin
        push_read($urandom_range(0, 3));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_total < issued_total) @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands: %0d writes (%0d coalesced, %0d refused as full),",
             accepted_total, n_writes, n_merged, n_full);
    $display("%0d reads returning %0d events, %0d of them finding nothing; %0d mismatches.",
             n_reads, n_returned, n_empty, error_count);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
